// ===== hdl/pip_pkg.sv =====
// shared types and constants of the point in polygon test unit
// no dependencies; imported by point_in_polygon_test_unit
package pip_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);
  localparam int unsigned CoordW      = 32;

  // operation codes of an input transaction
  localparam logic OpVertex = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef struct packed {
    logic                     op;
    logic                     restart;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic            inside_res;
    logic [CntW-1:0] crossing_count;
    logic [CntW-1:0] edge_count;
    logic            truncated;
  } out_t;

endpackage

// ===== hdl/point_in_polygon_test_unit.sv =====
// crossing-number point in polygon test over a stored polygon
// depends on pip_pkg for transaction types, sizes and operation codes
module point_in_polygon_test_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  pip_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output pip_pkg::out_t out_data_o
);
  // usage
  //   input channel: a vertex transaction (op = OpVertex) appends one point to
  //   the polygon store, emptying it first when restart is set; vertices past
  //   the store size are dropped and the truncated flag is raised.
  //   a query transaction (op = OpQuery) walks every edge of the polygon, the
  //   last vertex closing back to the first, and yields exactly one result
  //   transaction: crossing count, its parity, the vertex count and the truncated flag.
  //   vertex transactions produce no result.
  // sequencing
  //   a vertex transaction is written to the store as it is accepted.
  //   a query walks the polygon vertex by vertex: a vertex memory read, then
  //   an edge step; an empty polygon goes straight to the result. each
  //   straddling edge then takes two passes through the single 32 x 32
  //   multiplier plus a compare.
  //   input stall stays high for the whole query.
  // reset
  //   empties the polygon, clears the truncated flag and drops any pending result
  // stall on the output
  //   a finished result waits in the output register; vertex transactions are
  //   still taken meanwhile, and a following query completes its walk and then
  //   holds until the output register is free

  import pip_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StWait = 7'b0000010,
    StEdge = 7'b0000100,
    StMulA = 7'b0001000,
    StMulC = 7'b0010000,
    StCmp  = 7'b0100000,
    StDone = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // polygon store, undefined until written
  logic [CoordW-1:0] mem_x [MaxVertices];
  logic [CoordW-1:0] mem_y [MaxVertices];
  logic [CoordW-1:0] rd_x_q, rd_y_q;

  logic [CntW-1:0] total_q, total_d;
  logic            overflow_q, overflow_d;
  logic [CntW-1:0] k_q, k_d;         // index of the vertex closing the current edge
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q;

  // query point and edge end points
  logic signed [CoordW-1:0] px_q, py_q;
  logic [CoordW-1:0]        first_x_q, first_y_q;
  logic [CoordW-1:0]        prev_x_q, prev_y_q;

  // multiplier operands, sign and magnitude
  logic [CoordW-1:0]   a_mag_q, b_q, c_mag_q, d_q;
  logic                a_neg_q, c_neg_q;
  logic [2*CoordW-1:0] mul_q, p1_q;
  logic                n1_q;

  logic in_acc, out_acc;
  logic vtx_acc, qry_acc;
  logic full;
  logic wr_en;
  logic [AddrW-1:0] wr_addr;

  // edge setup
  logic [CoordW-1:0]        cur_x, cur_y;
  logic signed [CoordW-1:0] xi, xj;
  logic                     span;
  logic [CoordW:0]          dx, ex_w, ay, cy;
  logic                     dx_neg;
  logic [CoordW:0]          adx_w, a_mag_w, c_mag_w;
  logic                     last_edge;

  // shared multiplier and compare
  logic [CoordW-1:0]   mul_a, mul_b;
  logic                n2;
  logic                less;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign vtx_acc = in_acc && (in_data_i.op == OpVertex);
  assign qry_acc = in_acc && (in_data_i.op == OpQuery);

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // vertex append
  assign full    = (total_q == CntW'(MaxVertices));
  assign wr_en   = vtx_acc && (in_data_i.restart || !full);
  assign wr_addr = in_data_i.restart ? '0 : total_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_data_i.coord_x;
      mem_y[wr_addr] <= in_data_i.coord_y;
    end
    rd_x_q <= mem_x[k_q[AddrW-1:0]];
    rd_y_q <= mem_y[k_q[AddrW-1:0]];
  end

  // the closing edge ends at the first vertex
  assign last_edge = (k_q == total_q);
  assign cur_x     = last_edge ? first_x_q : rd_x_q;
  assign cur_y     = last_edge ? first_y_q : rd_y_q;

  assign xi   = $signed(prev_x_q);
  assign xj   = $signed(cur_x);
  assign span = ((xi <= px_q) && (px_q < xj)) || ((xj <= px_q) && (px_q < xi));

  // differences are 33 bits wide, magnitudes always fit in 32
  assign dx      = {xj[CoordW-1], xj} - {xi[CoordW-1], xi};
  assign dx_neg  = dx[CoordW];
  assign adx_w   = dx_neg ? (~dx + 1'b1) : dx;
  assign ex_w    = dx_neg ? ({xi[CoordW-1], xi} - {px_q[CoordW-1], px_q})
                          : ({px_q[CoordW-1], px_q} - {xi[CoordW-1], xi});
  assign ay      = {py_q[CoordW-1], py_q} - {prev_y_q[CoordW-1], prev_y_q};
  assign cy      = {cur_y[CoordW-1], cur_y} - {prev_y_q[CoordW-1], prev_y_q};
  assign a_mag_w = ay[CoordW] ? (~ay + 1'b1) : ay;
  assign c_mag_w = cy[CoordW] ? (~cy + 1'b1) : cy;

  // one multiplier serves both products of an edge
  assign mul_a = (state_q == StMulC) ? c_mag_q : a_mag_q;
  assign mul_b = (state_q == StMulC) ? d_q : b_q;

  // below the edge line when (py - yi) * |dx| < (yj - yi) * ex
  assign n2   = c_neg_q && (mul_q != '0);
  assign less = (n1_q != n2) ? n1_q : (n1_q ? (mul_q < p1_q) : (p1_q < mul_q));

  // sequencer
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    overflow_d  = overflow_q;
    k_d         = k_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    if (vtx_acc) begin
      if (in_data_i.restart) begin
        total_d    = CntW'(1);
        overflow_d = 1'b0;
      end else if (full) begin
        overflow_d = 1'b1;
      end else begin
        total_d = total_q + 1'b1;
      end
    end

    case (state_q)
      StIdle: begin
        if (qry_acc) begin
          k_d     = '0;
          count_d = '0;
          state_d = (total_q == '0) ? StDone : StWait;
        end
      end
      StWait: begin
        state_d = StEdge;
      end
      StEdge: begin
        if (k_q == '0) begin
          k_d     = CntW'(1);
          state_d = StWait;
        end else if (span) begin
          state_d = StMulA;
        end else if (last_edge) begin
          state_d = StDone;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = StWait;
        end
      end
      StMulA: begin
        state_d = StMulC;
      end
      StMulC: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (less) begin
          count_d = count_q + 1'b1;
        end
        if (last_edge) begin
          state_d = StDone;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = StWait;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= '0;
      overflow_q  <= 1'b0;
      k_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      overflow_q  <= overflow_d;
      k_q         <= k_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (qry_acc) begin
      px_q <= in_data_i.coord_x;
      py_q <= in_data_i.coord_y;
    end
    if (state_q == StEdge) begin
      if (k_q == '0) begin
        first_x_q <= rd_x_q;
        first_y_q <= rd_y_q;
      end
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
      a_mag_q  <= a_mag_w[CoordW-1:0];
      a_neg_q  <= ay[CoordW];
      b_q      <= adx_w[CoordW-1:0];
      c_mag_q  <= c_mag_w[CoordW-1:0];
      c_neg_q  <= cy[CoordW];
      d_q      <= ex_w[CoordW-1:0];
    end
    if ((state_q == StMulA) || (state_q == StMulC)) begin
      mul_q <= mul_a * mul_b;
    end
    if (state_q == StMulC) begin
      p1_q <= mul_q;
      n1_q <= a_neg_q && (mul_q != '0);
    end
    if ((state_q == StDone) && (!out_valid_q || !out_stall_i)) begin
      out_q.inside_res     <= count_q[0];
      out_q.crossing_count <= count_q;
      out_q.edge_count     <= total_q;
      out_q.truncated      <= overflow_q;
    end
  end

endmodule

// ===== test/point_in_polygon_test_unit_test.sv =====
// self-checking testbench of point_in_polygon_test_unit: directed and random
// polygons and queries, checked against a scoreboard that predicts every verdict
// depends on pip_pkg and point_in_polygon_test_unit
module point_in_polygon_test_unit_test;
  import pip_pkg::*;

  localparam int RandomItems  = 580;
  localparam int SettleCycles = MaxVertices + 100;
  localparam logic signed [CoordW-1:0] MinC = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] MaxC = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] One  = 32'sh0001_0000; // 1.0 in q16.16

  // keeps its own copy of the polygon store and predicts each query verdict
  class polygon_scoreboard;
    longint       vert_x[MaxVertices];
    longint       vert_y[MaxVertices];
    int unsigned  vert_total;
    bit           overflow_seen;
    out_t         expected_verdicts[$];
    int           errors, vertices, queries, checked, inside_seen, trunc_seen, max_edges;

    function new();
      vert_total    = 0;
      overflow_seen = 0;
      errors        = 0;
      vertices      = 0;
      queries       = 0;
      checked       = 0;
      inside_seen   = 0;
      trunc_seen    = 0;
      max_edges     = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // edges whose x span [min, max) holds px and whose line lies strictly above the point
    function int unsigned count_crossings(longint px, longint py);
      int unsigned          c, j;
      longint               xi, yi, xj, yj, dx, adx, ex;
      logic signed [95:0]   a, b, p, q;
      c = 0;
      for (int unsigned i = 0; i < vert_total; i++) begin
        j  = (i + 1 == vert_total) ? 0 : i + 1;
        xi = vert_x[i];
        yi = vert_y[i];
        xj = vert_x[j];
        yj = vert_y[j];
        if ((xi <= px && px < xj) || (xj <= px && px < xi)) begin
          dx  = xj - xi;
          adx = (dx < 0) ? -dx : dx;
          ex  = (dx < 0) ? (xi - px) : (px - xi);
          // below the line, cross-multiplied so no division is needed
          a = py - yi;
          b = adx;
          p = yj - yi;
          q = ex;
          if (a * b < p * q) c++;
        end
      end
      return c;
    endfunction

    function void note_transaction(in_t t);
      int unsigned cnt;
      out_t        v;
      if (t.op == OpVertex) begin
        vertices++;
        if (t.restart) begin
          vert_total    = 0;
          overflow_seen = 0;
        end
        if (vert_total < MaxVertices) begin
          vert_x[vert_total] = longint'(t.coord_x);
          vert_y[vert_total] = longint'(t.coord_y);
          vert_total++;
        end else begin
          overflow_seen = 1;
        end
      end else begin
        // restart is ignored on queries
        queries++;
        cnt              = count_crossings(longint'(t.coord_x), longint'(t.coord_y));
        v.inside_res     = cnt[0];
        v.crossing_count = CntW'(cnt);
        v.edge_count     = CntW'(vert_total);
        v.truncated      = overflow_seen;
        expected_verdicts.insert(expected_verdicts.size(), v);
      end
    endfunction

    function void check_verdict(out_t got);
      out_t e;
      if (expected_verdicts.size() == 0) begin
        report("result transaction with no query waiting");
        return;
      end
      e = expected_verdicts.pop_front();
      checked++;
      if (got.inside_res !== e.inside_res)
        report($sformatf("inside_res got %0b expected %0b", got.inside_res, e.inside_res));
      if (got.crossing_count !== e.crossing_count)
        report($sformatf("crossing_count got %0d expected %0d",
                         got.crossing_count, e.crossing_count));
      if (got.edge_count !== e.edge_count)
        report($sformatf("edge_count got %0d expected %0d", got.edge_count, e.edge_count));
      if (got.truncated !== e.truncated)
        report($sformatf("truncated got %0b expected %0b", got.truncated, e.truncated));
      if (e.inside_res) inside_seen++;
      if (e.truncated) trunc_seen++;
      if (int'(e.edge_count) > max_edges) max_edges = int'(e.edge_count);
    endfunction
  endclass

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;

  polygon_scoreboard sb;

  // stimulus side copy of the polygon, used only to aim queries at vertices and edges
  logic signed [CoordW-1:0] poly_x[$];
  logic signed [CoordW-1:0] poly_y[$];
  bit  no_gaps   = 1'b0;
  int  random_sent = 0;

  always #5 clk_i = ~clk_i;

  point_in_polygon_test_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // monitor: values read here are the ones before this edge's updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_transaction(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_verdict(out_data_o);
    end
  end

  // receiver back-pressure: free-flowing stretches, short stalls and the odd long one
  initial begin : receiver_stall
    int len;
    bit hold;
    forever begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin hold = 1'b0; len = $urandom_range(1, 40); end
        4, 5, 6, 7: begin hold = 1'b1; len = $urandom_range(1, 3);  end
        8:          begin hold = 1'b1; len = $urandom_range(4, 12); end
        default:    begin hold = 1'b1; len = $urandom_range(20, 60); end
      endcase
      @(posedge clk_i);
      out_stall_i <= hold;
      repeat (len - 1) @(posedge clk_i);
    end
  end

  // sender idle length, mostly short with a few long pauses
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transaction, held until accepted
  task automatic send_item(logic op, logic restart, logic signed [CoordW-1:0] x,
                           logic signed [CoordW-1:0] y);
    int  gap;
    in_t t;
    gap       = pick_gap();
    t.op      = op;
    t.restart = restart;
    t.coord_x = x;
    t.coord_y = y;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic add_vertex(logic restart, logic signed [CoordW-1:0] x,
                            logic signed [CoordW-1:0] y);
    if (restart) begin
      poly_x.delete();
      poly_y.delete();
    end
    poly_x.insert(poly_x.size(), x);
    poly_y.insert(poly_y.size(), y);
    send_item(OpVertex, restart, x, y);
  endtask

  // sender holds off until every outstanding verdict has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // coordinate scales: full range, integer grid, tiny raw values, extremes
  function automatic logic signed [CoordW-1:0] rand_coord(int scale);
    logic signed [CoordW-1:0] r;
    case (scale)
      0: r = $urandom;
      1: begin
        r = $urandom_range(0, 16);
        r = (r - 8) <<< 16;
      end
      2: begin
        r = $urandom_range(0, 2000);
        r = r - 1000;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       r = MinC;
          1:       r = MaxC;
          2:       r = '0;
          3:       r = '1;
          default: r = One;
        endcase
      end
    endcase
    return r;
  endfunction

  // query point: random, on a vertex, on a vertex column or row, or mid-edge
  task automatic pick_query(input int scale, output logic signed [CoordW-1:0] qx,
                            output logic signed [CoordW-1:0] qy);
    int k, m;
    k  = 0;
    m  = 0;
    qx = rand_coord(scale);
    qy = rand_coord(scale);
    if (poly_x.size() != 0) begin
      k = $urandom_range(0, poly_x.size() - 1);
      m = (k + 1) % poly_x.size();
      case ($urandom_range(0, 9))
        4, 5: qx = poly_x[k];
        6: begin
          qx = poly_x[k];
          qy = poly_y[k];
        end
        7: begin
          qx = (poly_x[k] >>> 1) + (poly_x[m] >>> 1);
          qy = (poly_y[k] >>> 1) + (poly_y[m] >>> 1);
        end
        8: qy = poly_y[k];
        9: begin
          qx = $urandom;
          qy = $urandom;
        end
        default: ;
      endcase
    end
  endtask

  // one polygon with a few queries, or a burst of noise
  task automatic random_round();
    int sel, scale, nv, nq;
    logic signed [CoordW-1:0] qx, qy;
    no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 99) < 85) begin
      sel   = $urandom_range(0, 9);
      scale = (sel < 3) ? 1 : (sel < 6) ? 2 : (sel < 9) ? 0 : 3;
      sel   = $urandom_range(0, 19);
      nv    = (sel == 0) ? $urandom_range(0, 2) :
              (sel == 1) ? $urandom_range(13, 60) : $urandom_range(3, 12);
      for (int k = 0; k < nv; k++) begin
        // now and then a polygon grows on from the previous one
        add_vertex((k == 0) && ($urandom_range(0, 9) != 0), rand_coord(scale),
                   rand_coord(scale));
        random_sent++;
      end
      nq = $urandom_range(1, 6);
      repeat (nq) begin
        pick_query(scale, qx, qy);
        send_item(OpQuery, 1'($urandom_range(0, 1)), qx, qy);
        random_sent++;
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) == 0)
          add_vertex(1'($urandom_range(0, 1)), $urandom, $urandom);
        else
          send_item(OpQuery, 1'($urandom_range(0, 1)), $urandom, $urandom);
        random_sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic signed [CoordW-1:0] qx, qy;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, restart flag on a query has no effect
    send_item(OpQuery, 1'b1, '0, '0);
    // single vertex: no edge spans any x
    add_vertex(1'b1, One, One);
    send_item(OpQuery, 1'b0, One, '0);
    // square at the coordinate extremes, with two vertical edges
    add_vertex(1'b1, MinC, MinC);
    add_vertex(1'b0, MaxC, MinC);
    add_vertex(1'b0, MaxC, MaxC);
    add_vertex(1'b0, MinC, MaxC);
    send_item(OpQuery, 1'b0, '0, '0);
    send_item(OpQuery, 1'b0, MinC, '0);   // left end of the span is included
    send_item(OpQuery, 1'b0, MaxC, '0);   // right end is not
    send_item(OpQuery, 1'b0, '0, MaxC);   // on the top edge, not strictly below
    send_item(OpQuery, 1'b1, '0, MinC);   // on the bottom edge
    // triangle on the grid: inside, apex, outside and on a sloped edge
    add_vertex(1'b1, -4 * One, -4 * One);
    add_vertex(1'b0, 4 * One, -4 * One);
    add_vertex(1'b0, '0, 4 * One);
    send_item(OpQuery, 1'b0, '0, '0);
    send_item(OpQuery, 1'b1, '0, 4 * One);
    send_item(OpQuery, 1'b0, 5 * One, '0);
    send_item(OpQuery, 1'b0, 2 * One, '0);
    send_item(OpQuery, 1'b0, -2 * One, '0);
    wait_drain();

    // fill the store to capacity, then overflow it and restart
    no_gaps = 1'b1;
    for (int k = 0; k < MaxVertices; k++)
      add_vertex(k == 0, rand_coord(1), rand_coord(1));
    pick_query(1, qx, qy);
    send_item(OpQuery, 1'b0, qx, qy);
    add_vertex(1'b0, rand_coord(1), rand_coord(1));  // dropped, sets truncated
    pick_query(1, qx, qy);
    send_item(OpQuery, 1'b0, qx, qy);
    add_vertex(1'b1, '0, '0);
    add_vertex(1'b0, 2 * One, '0);
    add_vertex(1'b0, One, 2 * One);
    send_item(OpQuery, 1'b0, One, One);
    wait_drain();
    no_gaps = 1'b0;

    while (random_sent < RandomItems) begin
      random_round();
      if ($urandom_range(0, 15) == 0) wait_drain();
    end

    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("run covered %0d vertex and %0d query transactions, %0d verdicts checked",
             sb.vertices, sb.queries, sb.checked);
    $display("%0d verdicts inside, %0d from a truncated store, largest polygon %0d vertices",
             sb.inside_seen, sb.trunc_seen, sb.max_edges);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pip_pkg.sv
hdl/point_in_polygon_test_unit.sv
test/point_in_polygon_test_unit_test.sv
